// File: hdl/hold_tap_key_resolver_macros.svh
// ----------------------------------------------------------------------------
// Hold-tap key resolver assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in rst.
// ----------------------------------------------------------------------------
`ifndef HOLD_TAP_KEY_RESOLVER_MACROS_SVH
`define HOLD_TAP_KEY_RESOLVER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HTKR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HTKR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/htkr_pkg.sv
// ----------------------------------------------------------------------------
// Hold-tap key resolver package
// Operation, tracker phase and action codes shared by the resolver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package htkr_pkg;

  typedef logic [1:0] op_t;
  typedef logic [1:0] phase_t;
  typedef logic [3:0] action_t;

  // Input operations.
  localparam op_t OP_PRESS   = 2'd0;
  localparam op_t OP_RELEASE = 2'd1;
  localparam op_t OP_TIMEOUT = 2'd2;
  localparam op_t OP_RESOLVE = 2'd3;

  // Tracker phases.
  localparam phase_t PH_IDLE    = 2'd0;
  localparam phase_t PH_PRESSED = 2'd1;
  localparam phase_t PH_HOLD    = 2'd2;

  // Result actions.
  localparam action_t ACT_DONE         = 4'd0;
  localparam action_t ACT_LAYER_ON     = 4'd1;
  localparam action_t ACT_LAYER_OFF    = 4'd2;
  localparam action_t ACT_MODS_PRESS   = 4'd3;
  localparam action_t ACT_MODS_RELEASE = 4'd4;
  localparam action_t ACT_LAZY_FLUSH   = 4'd5;
  localparam action_t ACT_KEY_PRESS    = 4'd6;
  localparam action_t ACT_KEY_RELEASE  = 4'd7;
  localparam action_t ACT_TAP_NOTIFY   = 4'd8;

  // Configuration register indexes.
  localparam logic [1:0] CFG_TAG_BYTE     = 2'd0;
  localparam logic [1:0] CFG_DEFAULT_TERM = 2'd1;

  // Targets below this value are layers; others are modifier masks.
  localparam logic [7:0] LAYER_COUNT = 8'd16;

  // Timeout after reset, in ticks.
  localparam logic [15:0] DEFAULT_TERM_RST = 16'd200;

endpackage

// File: hdl/hold_tap_key_resolver.sv
// Sequencing: an untagged press or release goes straight to its done item; other
// items scan the tracker table in order, and a release that resolves to a tap
// emits its tap sequence before the done item.
// Flow: a new item is taken only once the done item of the last has been emitted;
// the scan and the tap sequence stall while a result is held unaccepted.
// Reset: synchronous; all trackers idle, tag_byte 0, default_term 200.
// ----------------------------------------------------------------------------
// Hold-tap key resolver
// Tracks dual-role keys from press to release and resolves them to tap or
// hold actions, scanning the tracker table one entry per cycle unless results stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "hold_tap_key_resolver_macros.svh"

module hold_tap_key_resolver
  import htkr_pkg::*;
#(
  parameter int NUM_TRACKERS = 8
) (
  input  logic        clk,
  input  logic        rst,
  // Input item stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [79:0] s_tdata,   // key_row, key_col, key_code, now_tick
  input  logic [1:0]  s_tuser,   // op
  // Result item stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // action_value, handled, ticks_left, zero pad
  output logic [3:0]  m_tuser,   // action
  output logic        m_tlast,   // is_last
  // Configuration writes.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int IDX_W = (NUM_TRACKERS > 1) ? $clog2(NUM_TRACKERS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TRACKERS - 1);

  // Sequencer states.
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_TAP  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  // Configuration registers.
  logic [7:0]  tag_byte;
  logic [15:0] default_term;

  // Tracker table.
  phase_t      phase     [NUM_TRACKERS];
  logic [7:0]  trk_row   [NUM_TRACKERS];
  logic [7:0]  trk_col   [NUM_TRACKERS];
  logic [15:0] trk_act   [NUM_TRACKERS];
  logic [31:0] trk_start [NUM_TRACKERS];
  logic [15:0] trk_limit [NUM_TRACKERS];

  // Sequencer and latched item.
  logic [1:0]       state, state_next;
  logic [IDX_W-1:0] idx;
  op_t              op_q;
  logic [7:0]       row_q;
  logic [7:0]       col_q;
  logic [23:0]      code_q;
  logic [31:0]      now_q;
  logic             handled_q;
  logic [31:0]      minrem;
  logic [1:0]       tap_step;
  logic [7:0]       tap_kc;

  // Output register.
  logic        out_valid;
  action_t     out_action;
  logic [7:0]  out_value;
  logic        out_handled;
  logic [31:0] out_minrem;
  logic        out_last;

  // Shared scan unit and decisions.
  phase_t      cur_phase;
  logic        cur_match;
  logic [7:0]  cur_target;
  logic [31:0] elapsed;
  logic [31:0] lim_ext;
  logic [31:0] remain;
  logic        expired;
  logic        out_free;
  logic        in_tagged;
  logic        in_accept;
  logic        go_next;
  logic        step;
  logic        ph_we;
  phase_t      ph_wval;
  logic        fill;
  logic        min_we;
  logic        tap_start;
  logic        emit;
  action_t     em_act;
  logic [7:0]  em_val;
  logic        em_hand;
  logic [31:0] em_min;
  logic        em_last;

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_accept = s_tvalid && s_tready;
  assign in_tagged = (s_tdata[47:40] == tag_byte);
  assign out_free  = !out_valid || m_tready;

  assign m_tvalid = out_valid;
  assign m_tuser  = out_action;
  assign m_tlast  = out_last;
  assign m_tdata  = {7'd0, out_minrem, out_handled, out_value};

  // Read the tracker under the scan index and compare against the time limit.
  assign cur_phase  = phase[idx];
  assign cur_match  = (trk_row[idx] == row_q) && (trk_col[idx] == col_q);
  assign cur_target = trk_act[idx][15:8];
  assign elapsed    = now_q - trk_start[idx];
  assign lim_ext    = {16'd0, trk_limit[idx]};
  assign expired    = (elapsed >= lim_ext);
  assign remain     = lim_ext - elapsed;

  // Sequencer decisions for this cycle.
  always_comb begin
    state_next = state;
    go_next    = 1'b0;
    step       = 1'b0;
    ph_we      = 1'b0;
    ph_wval    = PH_IDLE;
    fill       = 1'b0;
    min_we     = 1'b0;
    tap_start  = 1'b0;
    emit       = 1'b0;
    em_act     = ACT_DONE;
    em_val     = 8'd0;
    em_hand    = 1'b0;
    em_min     = 32'd0;
    em_last    = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_accept) begin
          if ((s_tuser == OP_PRESS || s_tuser == OP_RELEASE) && !in_tagged) begin
            state_next = ST_DONE;
          end else begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (out_free) begin
          go_next = 1'b1;
          case (op_q)
            OP_PRESS: begin
              // First idle tracker takes the key.
              if (cur_phase == PH_IDLE) begin
                fill       = 1'b1;
                ph_we      = 1'b1;
                ph_wval    = PH_PRESSED;
                go_next    = 1'b0;
                state_next = ST_DONE;
              end
            end
            OP_RELEASE: begin
              // First live tracker at this position is freed.
              if (cur_phase != PH_IDLE && cur_match) begin
                ph_we   = 1'b1;
                ph_wval = PH_IDLE;
                emit    = 1'b1;
                go_next = 1'b0;
                if (cur_phase == PH_PRESSED) begin
                  em_act     = ACT_LAZY_FLUSH;
                  tap_start  = 1'b1;
                  state_next = ST_TAP;
                end else begin
                  em_act     = (cur_target < LAYER_COUNT) ? ACT_LAYER_OFF : ACT_MODS_RELEASE;
                  em_val     = cur_target;
                  state_next = ST_DONE;
                end
              end
            end
            OP_TIMEOUT: begin
              if (cur_phase == PH_PRESSED) begin
                if (expired) begin
                  ph_we   = 1'b1;
                  ph_wval = PH_HOLD;
                  emit    = 1'b1;
                  em_act  = (cur_target < LAYER_COUNT) ? ACT_LAYER_ON : ACT_MODS_PRESS;
                  em_val  = cur_target;
                end else if (remain < minrem) begin
                  min_we = 1'b1;
                end
              end
            end
            default: begin
              // Permissive resolve: every other pressed key becomes a hold.
              if (cur_phase == PH_PRESSED && !cur_match) begin
                ph_we   = 1'b1;
                ph_wval = PH_HOLD;
                emit    = 1'b1;
                em_act  = (cur_target < LAYER_COUNT) ? ACT_LAYER_ON : ACT_MODS_PRESS;
                em_val  = cur_target;
              end
            end
          endcase
          if (go_next) begin
            if (idx == LAST_IDX) begin
              state_next = ST_DONE;
            end else begin
              step = 1'b1;
            end
          end
        end
      end
      ST_TAP: begin
        // Remaining items of the tap sequence.
        if (out_free) begin
          emit = 1'b1;
          case (tap_step)
            2'd0: begin
              em_act = ACT_KEY_PRESS;
              em_val = tap_kc;
            end
            2'd1: begin
              em_act = ACT_KEY_RELEASE;
              em_val = tap_kc;
            end
            default: begin
              em_act     = ACT_TAP_NOTIFY;
              state_next = ST_DONE;
            end
          endcase
        end
      end
      default: begin
        // Closing done item.
        if (out_free) begin
          emit       = 1'b1;
          em_act     = ACT_DONE;
          em_hand    = handled_q;
          em_min     = (op_q == OP_TIMEOUT) ? minrem : 32'd0;
          em_last    = 1'b1;
          state_next = ST_IDLE;
        end
      end
    endcase
  end

  // Control state, configuration and tracker phases.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      out_valid    <= 1'b0;
      tag_byte     <= 8'd0;
      default_term <= DEFAULT_TERM_RST;
      for (int k = 0; k < NUM_TRACKERS; k++) begin
        phase[k] <= PH_IDLE;
      end
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_TAG_BYTE) begin
          tag_byte <= cfg_data[7:0];
        end else if (cfg_index == CFG_DEFAULT_TERM) begin
          default_term <= cfg_data;
        end
      end
      if (ph_we) begin
        phase[idx] <= ph_wval;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_q      <= s_tuser;
      row_q     <= s_tdata[7:0];
      col_q     <= s_tdata[15:8];
      code_q    <= s_tdata[39:16];
      now_q     <= s_tdata[79:48];
      handled_q <= (s_tuser == OP_PRESS || s_tuser == OP_RELEASE) && in_tagged;
      idx       <= '0;
      minrem    <= '1;
    end else begin
      if (step) begin
        idx <= idx + 1'b1;
      end
      if (min_we) begin
        minrem <= remain;
      end
    end
    if (fill) begin
      trk_row[idx]   <= row_q;
      trk_col[idx]   <= col_q;
      trk_act[idx]   <= code_q[15:0];
      trk_start[idx] <= now_q;
      trk_limit[idx] <= (code_q[23:16] != 8'd0) ? {8'd0, code_q[23:16]} : default_term;
    end
    if (tap_start) begin
      tap_kc   <= trk_act[idx][7:0];
      tap_step <= 2'd0;
    end else if (state == ST_TAP && out_free) begin
      tap_step <= tap_step + 2'd1;
    end
    if (emit) begin
      out_action  <= em_act;
      out_value   <= em_val;
      out_handled <= em_hand;
      out_minrem  <= em_min;
      out_last    <= em_last;
    end
  end

  // Checks on sequencing and result contents.
  `HTKR_ASSERT_NEXT(a_accept_busy, in_accept, !s_tready, "input accepted but block still ready")
  `HTKR_ASSERT_NOW(a_last_is_done, m_tvalid && m_tlast, m_tuser == ACT_DONE, "last item not done")
  `HTKR_ASSERT_NOW(a_extra_zero, m_tvalid && m_tuser != ACT_DONE, m_tdata[40:8] == 33'd0, "status set on action item")
  `HTKR_ASSERT_NOW(a_tap_step, state == ST_TAP, tap_step != 2'd3, "tap sequence overran")

endmodule

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// Hold-tap key resolver testbench
// Streams key events into the resolver and checks every resolved action
// against an in-bench predictor of the tracker table. A directed run covers
// the tap, hold, wrap, drop and no-match cases. Random phases then follow
// under several register settings and idle patterns, with one long hold-off
// on the result side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import htkr_pkg::*;

  localparam int NTRK = 8;
  localparam int QUIET_CYCLES = 2 * (NTRK + 5);
  localparam int STALL_LIMIT = 3000;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int PHASES = 8;
  localparam int ITEMS_PER_PHASE = 32;

  // Register indexes the block ignores.
  localparam logic [1:0] CFG_UNUSED_2 = 2'd2;
  localparam logic [1:0] CFG_UNUSED_3 = 2'd3;

  typedef struct packed {
    op_t         op;
    logic [7:0]  row;
    logic [7:0]  col;
    logic [31:0] code;
    logic [31:0] now;
  } key_event_t;

  typedef struct packed {
    action_t     action;
    logic [7:0]  value;
    logic        handled;
    logic [31:0] min_rem;
    logic        last;
  } key_action_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [79:0] s_tdata = '0;   // key_row, key_col, key_code, now_tick
  logic [1:0]  s_tuser = '0;   // op
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;        // action_value, handled, ticks_left, zero pad
  logic [3:0]  m_tuser;        // action
  logic        m_tlast;        // is_last
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  hold_tap_key_resolver #(.NUM_TRACKERS(NTRK)) uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Predictor copy of the registers and the tracker table.
  logic [7:0]  cfg_tag = 8'h00;
  logic [15:0] cfg_term = DEFAULT_TERM_RST;
  phase_t      trk_phase [NTRK];
  logic [7:0]  trk_row [NTRK];
  logic [7:0]  trk_col [NTRK];
  logic [15:0] trk_action [NTRK];
  logic [31:0] trk_start [NTRK];
  logic [15:0] trk_limit [NTRK];

  key_event_t  pending_events [$];
  key_action_t expected_actions [$];
  key_event_t  offered_event;
  bit          offer_live = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  bit          hold_request = 0;
  int          hold_left = 0;
  int          errors = 0;
  int          quiet_count = 0;

  task automatic push_action(input action_t act, input logic [7:0] val,
                             input logic hand, input logic [31:0] minrem,
                             input logic last);
    key_action_t a;
    a.action = act;
    a.value = val;
    a.handled = hand;
    a.min_rem = minrem;
    a.last = last;
    expected_actions.push_back(a);
  endtask

  // A tracker that resolves to hold turns on a layer or presses modifiers.
  task automatic promote_to_hold(input int t);
    logic [7:0] tgt;
    tgt = trk_action[t][15:8];
    trk_phase[t] = PH_HOLD;
    if (tgt < LAYER_COUNT) push_action(ACT_LAYER_ON, tgt, 1'b0, 32'd0, 1'b0);
    else push_action(ACT_MODS_PRESS, tgt, 1'b0, 32'd0, 1'b0);
  endtask

  // Works out the actions one accepted key event causes and updates the table.
  task automatic resolve_event(input key_event_t ev);
    logic        is_tagged;
    logic [31:0] elapsed;
    logic [31:0] lim;
    logic [31:0] least;
    logic [7:0]  tgt;
    logic [7:0]  kc;
    bit          found;
    int          i;
    is_tagged = (ev.code[31:24] == cfg_tag);
    found = 0;
    case (ev.op)
      OP_PRESS: begin
        if (is_tagged) begin
          for (i = 0; i < NTRK; i++) begin
            if (!found && trk_phase[i] == PH_IDLE) begin
              trk_row[i] = ev.row;
              trk_col[i] = ev.col;
              trk_action[i] = ev.code[15:0];
              trk_start[i] = ev.now;
              trk_limit[i] = (ev.code[23:16] != 8'h00) ? {8'h00, ev.code[23:16]} : cfg_term;
              trk_phase[i] = PH_PRESSED;
              found = 1;
            end
          end
        end
        push_action(ACT_DONE, 8'h00, is_tagged, 32'd0, 1'b1);
      end
      OP_RELEASE: begin
        if (is_tagged) begin
          for (i = 0; i < NTRK; i++) begin
            if (!found && trk_phase[i] != PH_IDLE && trk_row[i] == ev.row &&
                trk_col[i] == ev.col) begin
              tgt = trk_action[i][15:8];
              kc = trk_action[i][7:0];
              if (trk_phase[i] == PH_PRESSED) begin
                push_action(ACT_LAZY_FLUSH, 8'h00, 1'b0, 32'd0, 1'b0);
                push_action(ACT_KEY_PRESS, kc, 1'b0, 32'd0, 1'b0);
                push_action(ACT_KEY_RELEASE, kc, 1'b0, 32'd0, 1'b0);
                push_action(ACT_TAP_NOTIFY, 8'h00, 1'b0, 32'd0, 1'b0);
              end else if (tgt < LAYER_COUNT) begin
                push_action(ACT_LAYER_OFF, tgt, 1'b0, 32'd0, 1'b0);
              end else begin
                push_action(ACT_MODS_RELEASE, tgt, 1'b0, 32'd0, 1'b0);
              end
              trk_phase[i] = PH_IDLE;
              found = 1;
            end
          end
        end
        push_action(ACT_DONE, 8'h00, is_tagged, 32'd0, 1'b1);
      end
      OP_TIMEOUT: begin
        least = 32'hFFFF_FFFF;
        for (i = 0; i < NTRK; i++) begin
          if (trk_phase[i] == PH_PRESSED) begin
            elapsed = ev.now - trk_start[i];
            lim = {16'h0000, trk_limit[i]};
            if (elapsed >= lim) promote_to_hold(i);
            else if (lim - elapsed < least) least = lim - elapsed;
          end
        end
        push_action(ACT_DONE, 8'h00, 1'b0, least, 1'b1);
      end
      default: begin
        // Permissive resolve spares only trackers at the excepted position.
        for (i = 0; i < NTRK; i++) begin
          if (trk_phase[i] == PH_PRESSED && (trk_row[i] != ev.row || trk_col[i] != ev.col))
            promote_to_hold(i);
        end
        push_action(ACT_DONE, 8'h00, 1'b0, 32'd0, 1'b1);
      end
    endcase
  endtask

  // Input driver: presents the next pending item, holding it until accepted.
  always @(negedge clk) begin
    if (!rst && !offer_live) begin
      if (pending_events.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        offered_event = pending_events.pop_front();
        s_tdata <= {offered_event.now, offered_event.code, offered_event.col,
                    offered_event.row};
        s_tuser <= offered_event.op;
        s_tvalid <= 1'b1;
        offer_live = 1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Input monitor: predicts the results of each accepted item.
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      resolve_event(offered_event);
      offer_live = 0;
    end
  end

  // Result side ready, with random stalls and an occasional long hold-off.
  always @(negedge clk) begin
    if (hold_request) begin
      hold_left = HOLD_OFF_CYCLES;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Output monitor: compares each result item with the oldest expectation.
  always @(posedge clk) begin
    key_action_t got;
    key_action_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.action = m_tuser;
      got.value = m_tdata[7:0];
      got.handled = m_tdata[8];
      got.min_rem = m_tdata[40:9];
      got.last = m_tlast;
      if (expected_actions.size() == 0) begin
        $display("%0t: unexpected result item: action %0d value %0h handled %0b min %0h last %0b",
                 $time, got.action, got.value, got.handled, got.min_rem, got.last);
        errors++;
      end else begin
        want = expected_actions.pop_front();
        if (got !== want) begin
          $display("%0t: mismatch: expected action %0d value %0h handled %0b min %0h last %0b",
                   $time, want.action, want.value, want.handled, want.min_rem, want.last);
          $display("%0t:           actual   action %0d value %0h handled %0b min %0h last %0b",
                   $time, got.action, got.value, got.handled, got.min_rem, got.last);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles in which no handshake completes anywhere.
  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        quiet_count = 0;
      else
        quiet_count++;
      if (quiet_count >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("Verification failed");
        $finish;
      end
    end
  end

  task automatic queue_event(input op_t op, input logic [7:0] row, input logic [7:0] col,
                             input logic [31:0] code, input logic [31:0] now);
    key_event_t ev;
    ev.op = op;
    ev.row = row;
    ev.col = col;
    ev.code = code;
    ev.now = now;
    pending_events.push_back(ev);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_TAG_BYTE) cfg_tag = val[7:0];
    else if (idx == CFG_DEFAULT_TERM) cfg_term = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Waits until every item is in and every result is out, then lets the block settle.
  task automatic wait_for_drain();
    while (pending_events.size() != 0 || offer_live || expected_actions.size() != 0)
      @(negedge clk);
    repeat (QUIET_CYCLES) @(negedge clk);
  endtask

  // Stimulus sequencer.
  initial begin
    logic [15:0] held_keys [$];
    logic [15:0] pos;
    logic [31:0] rnd;
    logic [31:0] tick_now;
    logic [7:0]  row;
    logic [7:0]  col;
    logic [7:0]  term;
    logic [7:0]  target;
    logic [7:0]  jb;
    logic [7:0]  tag_sel;
    logic [15:0] term_sel;
    int          r;
    int          idx;
    int          j;
    int          p;
    int          n;

    for (j = 0; j < NTRK; j++) trk_phase[j] = PH_IDLE;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part at the reset register values.
    queue_event(OP_PRESS, 8'd0, 8'd0, 32'h0000_0504, 32'd1000);   // default term
    queue_event(OP_TIMEOUT, 8'd0, 8'd0, 32'd0, 32'd1100);
    queue_event(OP_TIMEOUT, 8'd0, 8'd0, 32'd0, 32'd1200);         // layer hold
    queue_event(OP_RELEASE, 8'd0, 8'd0, 32'h0000_0000, 32'd0);
    queue_event(OP_PRESS, 8'hFF, 8'hFF, 32'h000A_E12C, 32'hFFFF_FFFA);
    queue_event(OP_TIMEOUT, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 32'd4);  // tick wraps
    queue_event(OP_RELEASE, 8'hFF, 8'hFF, 32'h00FF_FFFF, 32'hFFFF_FFFF);
    queue_event(OP_PRESS, 8'd1, 8'd1, 32'h00FF_10FF, 32'd50);     // target at the layer bound
    queue_event(OP_RELEASE, 8'd1, 8'd1, 32'h0000_0000, 32'd60);   // tap sequence
    queue_event(OP_PRESS, 8'd4, 8'd4, 32'hFF00_0000, 32'd0);      // untagged
    queue_event(OP_RELEASE, 8'd4, 8'd4, 32'hFFFF_FFFF, 32'd0);
    queue_event(OP_RELEASE, 8'd9, 8'd9, 32'h0000_0000, 32'd0);    // no tracker
    queue_event(OP_PRESS, 8'd2, 8'd2, 32'h0000_2001, 32'd70);     // same position twice
    queue_event(OP_PRESS, 8'd2, 8'd2, 32'h0000_0302, 32'd71);
    queue_event(OP_RELEASE, 8'd2, 8'd2, 32'h0000_0000, 32'd72);
    held_keys.push_back({8'd2, 8'd2});
    // Fill the table until presses are dropped.
    for (j = 0; j < NTRK + 1; j++) begin
      jb = 8'(j);
      queue_event(OP_PRESS, 8'd3, jb,
                  {8'h00, 8'd20 + jb, (jb[0] ? (8'h80 | jb) : jb), jb}, 32'd100);
      held_keys.push_back({8'd3, jb});
    end
    queue_event(OP_RESOLVE, 8'd3, 8'd0, 32'd0, 32'd0);
    queue_event(OP_TIMEOUT, 8'd0, 8'd0, 32'd0, 32'd130);
    wait_for_drain();

    // Writes to indexes the block does not have.
    write_reg(CFG_UNUSED_2, 16'($urandom));
    write_reg(CFG_UNUSED_3, 16'($urandom));

    tick_now = 32'd5000;
    for (p = 0; p < PHASES; p++) begin
      rnd = $urandom;
      tag_sel = (p == 0) ? 8'hFF : (p == 1) ? 8'h00 : rnd[7:0];
      case (p)
        0: term_sel = 16'hFFFF;
        1: term_sel = 16'h0000;
        2: term_sel = 16'h0001;
        default: term_sel = 16'($urandom_range(20, 400));
      endcase
      write_reg(CFG_TAG_BYTE, {rnd[15:8], tag_sel});
      write_reg(CFG_DEFAULT_TERM, term_sel);
      case (p % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 49; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 49; end
        default: begin send_idle_pct = 7; recv_stall_pct = 7; end
      endcase
      if (p == 2) hold_request = 1;

      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        r = $urandom_range(99);
        rnd = $urandom;
        tick_now = tick_now + $urandom_range(0, 40);
        if ($urandom_range(49) == 0) tick_now = $urandom;
        if ($urandom_range(9) == 0) begin
          row = rnd[7:0];
          col = rnd[15:8];
        end else begin
          row = 8'($urandom_range(0, 3));
          col = 8'($urandom_range(0, 3));
        end
        if (r < 28) begin
          // Tagged press with a mix of own and default terms.
          case ($urandom_range(7))
            0, 1: term = 8'h00;
            2: term = 8'hFF;
            default: term = 8'($urandom_range(1, 60));
          endcase
          target = $urandom_range(1) ? 8'($urandom_range(0, 15)) : 8'($urandom_range(16, 255));
          queue_event(OP_PRESS, row, col, {cfg_tag, term, target, rnd[23:16]}, tick_now);
          held_keys.push_back({row, col});
        end else if (r < 56) begin
          if (held_keys.size() != 0) begin
            idx = $urandom_range(held_keys.size() - 1);
            pos = held_keys[idx];
            held_keys.delete(idx);
            row = pos[15:8];
            col = pos[7:0];
          end
          queue_event(OP_RELEASE, row, col, {cfg_tag, rnd[23:0]}, $urandom);
        end else if (r < 76) begin
          queue_event(OP_TIMEOUT, rnd[7:0], rnd[15:8], $urandom, tick_now);
        end else if (r < 86) begin
          // Permissive resolve, excepting a key that is still down when rnd[31] is set.
          if (held_keys.size() != 0 && rnd[31]) begin
            pos = held_keys[$urandom_range(held_keys.size() - 1)];
            row = pos[15:8];
            col = pos[7:0];
          end
          queue_event(OP_RESOLVE, row, col, $urandom, $urandom);
        end else if (r < 95) begin
          // Key without the tag, pressed or released.
          queue_event(rnd[31] ? OP_PRESS : OP_RELEASE, row, col,
                      {cfg_tag ^ 8'($urandom_range(1, 255)), rnd[23:0]}, tick_now);
        end else begin
          queue_event(op_t'($urandom_range(3)), rnd[7:0], rnd[15:8], $urandom, $urandom);
        end
      end
      wait_for_drain();
    end

    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
